// File: src/lmfe_pkg.sv
// shared types, codes and helpers for the lin master frame engine
package lmfe_pkg;

  // largest frame, data bytes plus checksum byte
  localparam int MAX_FRAME_BYTES = 9;
  localparam int DATA_N          = MAX_FRAME_BYTES - 1;
  localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W           = (DATA_N > 1) ? $clog2(DATA_N) : 1;

  // field widths
  localparam int BIT_TIME_W = 14;
  localparam int BREAK_W    = 5;
  localparam int TIMEOUT_W  = 16;
  localparam int BREAK_US_W = 19;
  localparam int CFG_W      = 16;

  // register reset values
  localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST = 14'd52;
  localparam logic [BREAK_W-1:0]    BREAK_RST    = 5'd13;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd50;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // register indexes
  localparam logic [1:0] CFG_BIT_TIME = 2'd0;
  localparam logic [1:0] CFG_BREAK    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;
  localparam logic [1:0] CFG_ENHANCED = 2'd3;

  // input modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_RX    = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BREAK  = 2'd0;
  localparam logic [1:0] KIND_TX     = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // frame status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_CHECKSUM    = 2'd1;
  localparam logic [1:0] ST_NO_RESPONSE = 2'd2;
  localparam logic [1:0] ST_ECHO_TO     = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ECHO,
    PH_RECV
  } phase_t;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_ECHO_TO,
    JOB_FINISH
  } job_kind_t;

  typedef logic [DATA_N-1:0][7:0] data_bytes_t;

  // one unit of work handed from front to back
  typedef struct packed {
    job_kind_t               kind;
    logic [7:0]              pid;
    logic [BREAK_US_W-1:0]   break_us;
    logic [BIT_TIME_W-1:0]   delimiter_us;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      count;
    data_bytes_t             data;
  } job_t;

  // one output beat
  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             byte_value;
    logic [BREAK_US_W-1:0]  break_us;
    logic [BIT_TIME_W-1:0]  delimiter_us;
    logic [1:0]             status;
    logic [3:0]             byte_count;
    logic                   last;
  } result_t;

  // protected id: parity p0 in bit 6, inverted parity p1 in bit 7
  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

// File: src/lmfe_front.sv
// front end: config registers, frame tracking, checksum and job issue
module lmfe_front import lmfe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    accept,
  input  logic [1:0]              mode,
  input  logic [5:0]              frame_id,
  input  logic [7:0]              rx_byte,
  output logic                    push,
  output job_t                    job
);

  logic [BIT_TIME_W-1:0] bit_time_us;
  logic [BREAK_W-1:0]    break_bits;
  logic [TIMEOUT_W-1:0]  timeout_ms;
  logic                  enhanced;

  phase_t                phase, phase_next;
  logic [7:0]            pid, pid_next;
  logic [TIMEOUT_W-1:0]  wait_ticks, wait_ticks_next;
  logic [COUNT_W-1:0]    rcount, rcount_next;
  logic [7:0]            running_sum, running_sum_next;
  logic [7:0]            sum_before_last, sum_before_last_next;
  logic [7:0]            last_byte, last_byte_next;
  data_bytes_t           buffer;

  logic [8:0]            sum9;
  logic [7:0]            folded;
  logic [COUNT_W-1:0]    rcount_inc;
  logic [BREAK_US_W-1:0] break_prod;
  logic                  rx_recv;
  logic                  echo_hit;
  logic                  frame_full;
  logic                  tick_live;
  logic                  expired;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time_us <= BIT_TIME_RST;
      break_bits  <= BREAK_RST;
      timeout_ms  <= TIMEOUT_RST;
      enhanced    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIT_TIME: bit_time_us <= cfg_data[BIT_TIME_W-1:0];
        CFG_BREAK:    break_bits  <= cfg_data[BREAK_W-1:0];
        CFG_TIMEOUT:  timeout_ms  <= cfg_data[TIMEOUT_W-1:0];
        CFG_ENHANCED: enhanced    <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // end-around-carry add and event decode
  assign sum9       = {1'b0, running_sum} + {1'b0, rx_byte};
  assign folded     = sum9[7:0] + {7'd0, sum9[8]};
  assign rcount_inc = rcount + COUNT_W'(1);
  assign break_prod = BREAK_US_W'(bit_time_us) * BREAK_US_W'(break_bits);
  assign rx_recv    = accept && (mode == MODE_RX) && (phase == PH_RECV);
  assign echo_hit   = accept && (mode == MODE_RX) && (phase == PH_ECHO) && (rx_byte == pid);
  assign frame_full = rx_recv && (rcount_inc >= COUNT_W'(MAX_FRAME_BYTES));
  assign tick_live  = accept && (mode == MODE_TICK) && (phase != PH_IDLE);
  assign expired    = tick_live && (wait_ticks >= timeout_ms);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept && (mode == MODE_START)) begin
      phase_next = PH_ECHO;
    end else if (echo_hit) begin
      phase_next = PH_RECV;
    end else if (frame_full || expired) begin
      phase_next = PH_IDLE;
    end
  end

  // datapath updates and job issue
  always_comb begin
    pid_next             = pid;
    wait_ticks_next      = wait_ticks;
    rcount_next          = rcount;
    running_sum_next     = running_sum;
    sum_before_last_next = sum_before_last;
    last_byte_next       = last_byte;
    push                 = 1'b0;
    job                  = '0;
    job.kind             = JOB_FINISH;
    job.data             = buffer;
    if (accept) begin
      case (mode)
        MODE_START: begin
          pid_next         = make_pid(frame_id);
          wait_ticks_next  = '0;
          rcount_next      = '0;
          push             = 1'b1;
          job.kind         = JOB_HEADER;
          job.pid          = make_pid(frame_id);
          job.break_us     = break_prod;
          job.delimiter_us = bit_time_us;
        end
        MODE_RX: begin
          if (phase == PH_ECHO) begin
            wait_ticks_next = '0;
            if (echo_hit) begin
              rcount_next          = '0;
              running_sum_next     = enhanced ? pid : 8'd0;
              sum_before_last_next = enhanced ? pid : 8'd0;
            end
          end else if (phase == PH_RECV) begin
            wait_ticks_next      = '0;
            last_byte_next       = rx_byte;
            sum_before_last_next = running_sum;
            running_sum_next     = folded;
            rcount_next          = rcount_inc;
            if (frame_full) begin
              push       = 1'b1;
              job.status = ((~running_sum) == rx_byte) ? ST_OK : ST_CHECKSUM;
              job.count  = rcount_inc;
            end
          end
        end
        MODE_TICK: begin
          if (tick_live) begin
            if (expired) begin
              push = 1'b1;
              if (phase == PH_ECHO) begin
                job.kind   = JOB_ECHO_TO;
                job.status = ST_ECHO_TO;
              end else if (rcount == '0) begin
                job.status = ST_NO_RESPONSE;
              end else begin
                job.status = ((~sum_before_last) == last_byte) ? ST_OK : ST_CHECKSUM;
                job.count  = rcount;
              end
            end else begin
              wait_ticks_next = wait_ticks + TIMEOUT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      pid             <= '0;
      wait_ticks      <= '0;
      rcount          <= '0;
      running_sum     <= '0;
      sum_before_last <= '0;
      last_byte       <= '0;
    end else begin
      phase           <= phase_next;
      pid             <= pid_next;
      wait_ticks      <= wait_ticks_next;
      rcount          <= rcount_next;
      running_sum     <= running_sum_next;
      sum_before_last <= sum_before_last_next;
      last_byte       <= last_byte_next;
    end
  end

  // data byte store; a ninth byte, the checksum of a full frame, is kept in last_byte only
  always_ff @(posedge clk) begin
    if (rx_recv && (rcount < COUNT_W'(DATA_N))) begin
      buffer[rcount[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// File: src/lmfe_queue.sv
// two-entry job queue between front and back
module lmfe_queue import lmfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_job   = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

// File: src/lmfe_back.sv
// back end: expands a job into output beats behind an output register
module lmfe_back import lmfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  job_t     head_job,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  logic [COUNT_W-1:0] step;
  result_t            res;
  logic               load;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && res.last;

  // beat for the current step of the head job
  always_comb begin
    res = '0;
    case (head_job.kind)
      JOB_HEADER: begin
        if (step == '0) begin
          res.kind         = KIND_BREAK;
          res.break_us     = head_job.break_us;
          res.delimiter_us = head_job.delimiter_us;
        end else if (step == COUNT_W'(1)) begin
          res.kind       = KIND_TX;
          res.byte_value = SYNC_BYTE;
        end else begin
          res.kind       = KIND_TX;
          res.byte_value = head_job.pid;
          res.last       = 1'b1;
        end
      end
      JOB_ECHO_TO: begin
        res.kind   = KIND_STATUS;
        res.status = head_job.status;
        res.last   = 1'b1;
      end
      JOB_FINISH: begin
        if ((head_job.count != '0) && (step < head_job.count - COUNT_W'(1))) begin
          res.kind       = KIND_DATA;
          res.byte_value = head_job.data[step[IDX_W-1:0]];
        end else begin
          res.kind       = KIND_STATUS;
          res.status     = head_job.status;
          res.byte_count = 4'(head_job.count);
          res.last       = 1'b1;
        end
      end
      default: begin
        res.kind = KIND_STATUS;
        res.last = 1'b1;
      end
    endcase
  end

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) out_valid <= head_valid;
      if (pop) begin
        step <= '0;
      end else if (load) begin
        step <= step + COUNT_W'(1);
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) out_res <= res;
  end

endmodule

// File: src/lin_master_frame_engine.sv
// top level of the lin master frame engine
//
// Input channel s_*: s_tuser carries the mode (start frame, bus byte, ms tick),
// s_tdata the frame id and the received byte. Output channel m_*: m_tuser is
// the result kind, m_tlast marks the final beat caused by one input item.
// Configuration registers are written through cfg_we / cfg_index / cfg_data.
//
// The front end takes one input beat per cycle while its two-entry job queue
// has room; each start, echo timeout or finished frame becomes one job. The
// back end turns the head job into 1 to 9 output beats, one per cycle while
// m_tready holds high, into an output register. A first result is registered
// in the queue, then in the output register. A start gives 3 beats, a finished
// frame max(1, bytes received) beats. The back end sets the sustained rate.
//
// Reset restores the register defaults, returns the frame tracker to idle
// and empties the queue. When m_tready is low the output beat holds, the
// queue fills, and s_tready drops once two jobs wait, for any input mode.
module lin_master_frame_engine import lmfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // frame_id[5:0], rx_byte[13:6], zero[15:14]
  input  logic [1:0]        s_tuser,   // mode[1:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // byte_value[7:0], break_us[26:8],
                                       // delimiter_us[40:27], status[42:41],
                                       // byte_count[46:43], zero[47]
  output logic [1:0]        m_tuser,   // kind[1:0]
  output logic              m_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic    accept;
  logic    push;
  job_t    push_job;
  logic    full;
  logic    pop;
  logic    head_valid;
  job_t    head_job;
  result_t out_res;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  lmfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .mode      (s_tuser),
    .frame_id  (s_tdata[5:0]),
    .rx_byte   (s_tdata[13:6]),
    .push      (push),
    .job       (push_job)
  );

  lmfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lmfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  // output beat packing
  assign m_tdata = {1'b0, out_res.byte_count, out_res.status, out_res.delimiter_us,
                    out_res.break_us, out_res.byte_value};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

// File: src/lmfe_checker.sv
// port-level checks on the output channel of the frame engine
module lmfe_checker import lmfe_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // no beat offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a status beat always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_STATUS)) |-> m_tlast)
    else $error("status beat without tlast");

  // a break request never closes a run
  a_break_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_BREAK)) |-> !m_tlast)
    else $error("break beat with tlast");

  // a taken break beat is followed at once by the sync byte
  a_break_then_sync: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && (m_tuser == KIND_BREAK)) |=>
      (m_tvalid && (m_tuser == KIND_TX) && (m_tdata[7:0] == SYNC_BYTE)))
    else $error("break not followed by sync byte");

endmodule

bind lin_master_frame_engine lmfe_checker u_lmfe_checker (.*);

// File: test/lin_master_frame_engine_tb.sv
// self-checking testbench for the lin master frame engine: directed table, then random frames
`timescale 1ns / 100ps

module lin_master_frame_engine_tb;
  import lmfe_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         SETTLE       = 16;
  localparam int         PHASE_ITEMS  = 40;
  localparam int         TICK_END_MAX = 64;

  // one row of the directed table: a register write or an input beat
  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        sel;
    logic [15:0]       value;
    logic [5:0]        fid;
    logic [7:0]        rx;
    logic [1:0]        n_typed;
    result_t [2:0]     typed;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b1;
  logic [47:0]      m_tdata;
  logic [1:0]       m_tuser;
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // register copies
  logic [13:0] cfg_bit_time = BIT_TIME_RST;
  logic [4:0]  cfg_break    = BREAK_RST;
  logic [15:0] cfg_timeout  = TIMEOUT_RST;
  logic        cfg_enh      = 1'b0;

  // frame tracker copy
  phase_t      eng_phase    = PH_IDLE;
  logic [7:0]  eng_pid      = '0;
  logic [15:0] eng_wait     = '0;
  logic [3:0]  eng_count    = '0;
  logic [7:0]  eng_buf [MAX_FRAME_BYTES];
  logic [7:0]  eng_sum      = '0;
  logic [7:0]  eng_prev_sum = '0;

  result_t   engine_beats [$];
  stim_row_t dir_rows [$];
  int        mismatches   = 0;
  int        beat_no      = 0;
  int        bus_items    = 0;
  int        cycle_count  = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;

  lin_master_frame_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // id with its two parity bits on top
  function automatic logic [7:0] lin_pid(input logic [5:0] id);
    return {~^{id[1], id[3], id[4], id[5]}, ^{id[0], id[1], id[2], id[4]}, id};
  endfunction

  function automatic result_t make_beat(input logic [1:0] kind, input logic [7:0] bv,
                                        input logic [18:0] brk, input logic [13:0] dl,
                                        input logic [1:0] st, input logic [3:0] cnt,
                                        input logic lst);
    result_t r;
    r.kind         = kind;
    r.byte_value   = bv;
    r.break_us     = brk;
    r.delimiter_us = dl;
    r.status       = st;
    r.byte_count   = cnt;
    r.last         = lst;
    return r;
  endfunction

  // end of a response: data beats then one status beat
  function automatic void close_frame();
    int         i;
    logic [1:0] st;
    eng_phase = PH_IDLE;
    if (eng_count == 0) begin
      engine_beats.push_back(make_beat(KIND_STATUS, 8'h00, '0, '0, ST_NO_RESPONSE, 4'd0, 1'b1));
    end else begin
      st = (~eng_prev_sum == eng_buf[eng_count - 1]) ? ST_OK : ST_CHECKSUM;
      for (i = 0; i + 1 < eng_count; i++) begin
        engine_beats.push_back(make_beat(KIND_DATA, eng_buf[i], '0, '0, 2'd0, 4'd0, 1'b0));
      end
      engine_beats.push_back(make_beat(KIND_STATUS, 8'h00, '0, '0, st, eng_count, 1'b1));
    end
  endfunction

  // advance the frame tracker by one input beat, queue the beats it causes
  function automatic void engine_step(input logic [1:0] mode, input logic [5:0] fid,
                                      input logic [7:0] rx);
    logic [31:0] prod;
    logic [8:0]  s;
    case (mode)
      MODE_START: begin
        eng_pid = lin_pid(fid);
        prod = cfg_bit_time * cfg_break;
        engine_beats.push_back(make_beat(KIND_BREAK, 8'h00, prod[18:0], cfg_bit_time,
                                         2'd0, 4'd0, 1'b0));
        engine_beats.push_back(make_beat(KIND_TX, SYNC_BYTE, '0, '0, 2'd0, 4'd0, 1'b0));
        engine_beats.push_back(make_beat(KIND_TX, eng_pid, '0, '0, 2'd0, 4'd0, 1'b1));
        eng_phase = PH_ECHO;
        eng_wait  = '0;
        eng_count = '0;
      end
      MODE_RX: begin
        if (eng_phase == PH_ECHO) begin
          eng_wait = '0;
          if (rx == eng_pid) begin
            eng_phase    = PH_RECV;
            eng_count    = '0;
            eng_sum      = cfg_enh ? eng_pid : 8'h00;
            eng_prev_sum = eng_sum;
          end
        end else if (eng_phase == PH_RECV) begin
          eng_wait = '0;
          eng_buf[eng_count] = rx;
          eng_prev_sum = eng_sum;
          // end-around carry
          s = eng_sum + rx;
          if (s > 9'd255) s = s - 9'd255;
          eng_sum   = s[7:0];
          eng_count = eng_count + 1;
          if (eng_count >= MAX_FRAME_BYTES) close_frame();
        end
      end
      MODE_TICK: begin
        if (eng_phase != PH_IDLE) begin
          if (eng_wait >= cfg_timeout) begin
            if (eng_phase == PH_ECHO) begin
              eng_phase = PH_IDLE;
              engine_beats.push_back(make_beat(KIND_STATUS, 8'h00, '0, '0, ST_ECHO_TO,
                                               4'd0, 1'b1));
            end else begin
              close_frame();
            end
          end else begin
            eng_wait = eng_wait + 1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(input logic [1:0] mode, input logic [5:0] fid,
                                   input logic [7:0] rx, input int n = 0,
                                   input result_t r0 = '0, input result_t r1 = '0,
                                   input result_t r2 = '0);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.sel     = mode;
    row.value   = '0;
    row.fid     = fid;
    row.rx      = rx;
    row.n_typed = 2'(n);
    row.typed   = {r2, r1, r0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.sel    = idx;
    row.value  = val;
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("beat %0d: %s is 0x%0h, predicted 0x%0h", beat_no, what, got, want);
    mismatches++;
  endtask

  // register write once the output side has drained
  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (engine_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BIT_TIME: cfg_bit_time = val[13:0];
      CFG_BREAK:    cfg_break    = val[4:0];
      CFG_TIMEOUT:  cfg_timeout  = val;
      CFG_ENHANCED: cfg_enh      = val[0];
      default: ;
    endcase
  endtask

  // one input beat; typed beats, if given, replace the predicted ones
  task automatic send_item(input logic [1:0] mode, input logic [5:0] fid,
                           input logic [7:0] rx, input int n_typed = 0,
                           input result_t [2:0] typed = '0);
    int base;
    int k;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, rx, fid};
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    if (mode == MODE_START || (mode != MODE_UNUSED && eng_phase != PH_IDLE)) bus_items++;
    base = engine_beats.size();
    engine_step(mode, fid, rx);
    if (n_typed > 0) begin
      while (engine_beats.size() > base) void'(engine_beats.pop_back());
      for (k = 0; k < n_typed; k++) engine_beats.push_back(typed[k]);
    end
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 6'($urandom), 8'($urandom));
  endtask

  // ticks until the frame gives up
  task automatic run_out_clock();
    while (eng_phase != PH_IDLE) send_tick();
  endtask

  // start plus some bus bytes that are not the echo
  task automatic send_header(input logic [5:0] fid, input int noise);
    logic [7:0] b;
    send_item(MODE_START, fid, 8'($urandom));
    repeat (noise) begin
      b = 8'($urandom);
      if (b == eng_pid) b = b ^ 8'h01;
      send_item(MODE_RX, 6'($urandom), b);
    end
  endtask

  // response bytes up to tgt, last one a correct checksum when good
  task automatic send_response(input int tgt, input bit good);
    int         gap_max;
    logic [7:0] b;
    gap_max = (cfg_timeout < 3) ? cfg_timeout : 3;
    if (tgt != 0 && tgt < eng_count + 1) tgt = eng_count + 1;
    while (eng_phase == PH_RECV && eng_count < tgt) begin
      if ($urandom_range(99) < 30) repeat ($urandom_range(0, gap_max)) send_tick();
      b = 8'($urandom);
      if (good && eng_count == tgt - 1) b = ~eng_sum;
      send_item(MODE_RX, 6'($urandom), b);
    end
  endtask

  // one random sequence: noise, a failed echo, or a frame with its response
  task automatic run_sequence();
    int r;
    int tgt;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 3)) send_item(2'($urandom), 6'($urandom), 8'($urandom));
    end else if (r < 18) begin
      send_header(6'($urandom), $urandom_range(0, 2));
      if (cfg_timeout <= TICK_END_MAX) run_out_clock();
    end else begin
      if (eng_phase != PH_RECV) begin
        send_header(6'($urandom), $urandom_range(0, 2));
        send_item(MODE_RX, 6'($urandom), eng_pid);
      end
      r = $urandom_range(99);
      if (cfg_timeout > TICK_END_MAX || r < 30) tgt = MAX_FRAME_BYTES;
      else if (r < 40) tgt = 0;
      else tgt = $urandom_range(1, MAX_FRAME_BYTES - 1);
      send_response(tgt, $urandom_range(99) < 75);
      if (cfg_timeout <= TICK_END_MAX) run_out_clock();
    end
  endtask

  // receiver stalls
  always @(posedge clk) m_tready <= ($urandom_range(99) >= snk_stall_pct);

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = {m_tuser, m_tdata[7:0], m_tdata[26:8], m_tdata[40:27], m_tdata[42:41],
              m_tdata[46:43], m_tlast};
      if (engine_beats.size() == 0) begin
        report_mismatch("unpredicted beat, kind", seen.kind, 0);
      end else begin
        want = engine_beats.pop_front();
        if (seen.kind !== want.kind) report_mismatch("kind", seen.kind, want.kind);
        if (seen.byte_value !== want.byte_value)
          report_mismatch("byte_value", seen.byte_value, want.byte_value);
        if (seen.break_us !== want.break_us)
          report_mismatch("break_us", seen.break_us, want.break_us);
        if (seen.delimiter_us !== want.delimiter_us)
          report_mismatch("delimiter_us", seen.delimiter_us, want.delimiter_us);
        if (seen.status !== want.status) report_mismatch("status", seen.status, want.status);
        if (seen.byte_count !== want.byte_count)
          report_mismatch("byte_count", seen.byte_count, want.byte_count);
        if (seen.last !== want.last) report_mismatch("last", seen.last, want.last);
      end
      beat_no++;
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int          p;
    int          start_items;
    logic [13:0] bt;
    logic [4:0]  bb;
    logic [15:0] to;
    logic        en;

    // directed table; typed beats where they follow from reset values or error codes
    add_item(MODE_RX, 6'd0, 8'hFF);
    add_item(MODE_TICK, 6'd63, 8'h00);
    add_item(MODE_UNUSED, 6'd63, 8'hFF);
    add_item(MODE_START, 6'd0, 8'h00, 3,
             make_beat(KIND_BREAK, 8'h00, 19'd676, 14'd52, 2'd0, 4'd0, 1'b0),
             make_beat(KIND_TX, SYNC_BYTE, '0, '0, 2'd0, 4'd0, 1'b0),
             make_beat(KIND_TX, 8'h80, '0, '0, 2'd0, 4'd0, 1'b1));
    add_cfg(CFG_TIMEOUT, 16'd1);
    add_item(MODE_TICK, 6'd0, 8'h00);
    add_item(MODE_TICK, 6'd0, 8'h00, 1,
             make_beat(KIND_STATUS, 8'h00, '0, '0, ST_ECHO_TO, 4'd0, 1'b1));
    add_item(MODE_START, 6'd63, 8'hFF, 3,
             make_beat(KIND_BREAK, 8'h00, 19'd676, 14'd52, 2'd0, 4'd0, 1'b0),
             make_beat(KIND_TX, SYNC_BYTE, '0, '0, 2'd0, 4'd0, 1'b0),
             make_beat(KIND_TX, 8'hBF, '0, '0, 2'd0, 4'd0, 1'b1));
    add_item(MODE_RX, 6'd0, 8'hBF);
    add_item(MODE_TICK, 6'd0, 8'h00);
    add_item(MODE_TICK, 6'd0, 8'h00, 1,
             make_beat(KIND_STATUS, 8'h00, '0, '0, ST_NO_RESPONSE, 4'd0, 1'b1));
    // enhanced sum, start while busy, full frame
    add_cfg(CFG_ENHANCED, 16'd1);
    add_item(MODE_START, 6'h15, 8'h00);
    add_item(MODE_START, 6'h2A, 8'h5A);
    add_item(MODE_RX, 6'd0, lin_pid(6'h2A));
    add_item(MODE_RX, 6'd0, 8'h00);
    add_item(MODE_RX, 6'd0, 8'hFF);
    add_item(MODE_RX, 6'd0, 8'h80);
    add_item(MODE_RX, 6'd0, 8'h01);
    add_item(MODE_RX, 6'd0, 8'h7F);
    add_item(MODE_RX, 6'd0, 8'hFE);
    add_item(MODE_RX, 6'd0, 8'h55);
    add_item(MODE_RX, 6'd0, 8'hAA);
    add_item(MODE_RX, 6'd0, 8'h3C);
    // classic sum, short frame with a good checksum
    add_cfg(CFG_ENHANCED, 16'd0);
    add_item(MODE_START, 6'd1, 8'h00);
    add_item(MODE_RX, 6'd0, lin_pid(6'd1));
    add_item(MODE_RX, 6'd0, 8'h01);
    add_item(MODE_RX, 6'd0, 8'hFE);
    add_item(MODE_TICK, 6'd0, 8'h00);
    add_item(MODE_TICK, 6'd0, 8'h00, 2,
             make_beat(KIND_DATA, 8'h01, '0, '0, 2'd0, 4'd0, 1'b0),
             make_beat(KIND_STATUS, 8'h00, '0, '0, ST_OK, 4'd2, 1'b1));

    // reset
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        set_reg(dir_rows[i].sel, dir_rows[i].value);
      end else begin
        send_item(dir_rows[i].sel, dir_rows[i].fid, dir_rows[i].rx,
                  dir_rows[i].n_typed, dir_rows[i].typed);
      end
    end

    // random phases over settings and idle patterns
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
        default: begin src_idle_pct = 12; snk_stall_pct = 12; end
      endcase
      case (p)
        0: begin bt = 14'd1;     bb = 5'd10; to = 16'd1;     en = 1'b0; end
        1: begin bt = 14'd10000; bb = 5'd31; to = 16'd3;     en = 1'b1; end
        2: begin bt = 14'd52;    bb = 5'd13; to = 16'd50;    en = 1'b0; end
        3: begin
          bt = 14'($urandom_range(1, 10000));
          bb = 5'($urandom_range(10, 31));
          to = 16'd65535;
          en = 1'b1;
        end
        default: begin
          bt = 14'($urandom_range(1, 10000));
          bb = 5'($urandom_range(10, 31));
          to = 16'($urandom_range(1, 6));
          en = 1'($urandom_range(0, 1));
        end
      endcase
      set_reg(CFG_BIT_TIME, 16'(bt));
      set_reg(CFG_BREAK, 16'(bb));
      set_reg(CFG_TIMEOUT, to);
      set_reg(CFG_ENHANCED, 16'(en));
      start_items = bus_items;
      while (bus_items - start_items < PHASE_ITEMS) run_sequence();
      // sometimes leave a frame open across the next register writes
      if ($urandom_range(99) < 40) begin
        send_header(6'($urandom), 0);
        send_item(MODE_RX, 6'($urandom), eng_pid);
        repeat (2) send_item(MODE_RX, 6'($urandom), 8'($urandom));
      end
    end

    // drain
    s_tvalid <= 1'b0;
    while (engine_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
